[rtl/sm3_pkg.sv]
// Shared types, constants and round functions of the SM3 hash engine.
package sm3_pkg;

   localparam logic [31:0] T_LOW     = 32'h79cc4519;
   localparam logic [31:0] T_HIGH    = 32'h7a879d8a;
   // T_HIGH already rotated by 16, the value it takes at round 16
   localparam logic [31:0] T_HIGH_16 = {T_HIGH[15:0], T_HIGH[31:16]};
   localparam logic [31:0] PAD_WORD  = 32'h80000000;
   localparam int          QDEPTH    = 4;
   localparam int          QPTR_W    = $clog2(QDEPTH);

   typedef logic [31:0]           word_type;
   typedef logic [0:7][31:0]      chain_type;
   typedef logic [2:0]            csr_index_type;

   localparam chain_type IV_RESET = '{
      32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
      32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e};

   // one block word on its way from the front to the back
   typedef struct packed {
      logic [31:0] word;
      logic        last;
   } qent_type;

   typedef enum logic [1:0] {FR_IDLE, FR_PAD80, FR_ZERO, FR_LEN_LO} front_state_type;
   typedef enum logic [1:0] {BK_LOAD, BK_ROUND, BK_DONE} back_state_type;

   function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
      rotl = (x << n) | (x >> (32 - n));
   endfunction

   function automatic logic [31:0] perm0(input logic [31:0] x);
      perm0 = x ^ rotl(x, 9) ^ rotl(x, 17);
   endfunction

   function automatic logic [31:0] perm1(input logic [31:0] x);
      perm1 = x ^ rotl(x, 15) ^ rotl(x, 23);
   endfunction

endpackage

[rtl/sm3_hash_engine.sv]
// Top level of the streaming SM3 hash engine.
//
// Requests carry one big-endian 32-bit message word each; every word but the
// last carries four bytes, the last (req_final_word) carries req_valid_bytes
// leading bytes, values above four counting as four. The front takes a word
// each cycle while its four-entry queue has room, and after a final word
// pushes the padding words in turn (0x80 byte, zeros, 64-bit bit length)
// before taking the next message. The back pulls 16 words from the queue,
// then runs one round per cycle: each block is loaded, put through 64 rounds
// and folded into the chaining value before the next loads, on the single round
// unit. One digest comes out per message, held in an output register until
// taken. The initial chaining words (csr_index 0 to 7) are sampled when a
// message's first block starts compressing; write them only while idle.
module sm3_hash_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_message_word,
   input  logic [2:0]  req_valid_bytes,
   input  logic        req_final_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_0,
   output logic [31:0] rsp_digest_1,
   output logic [31:0] rsp_digest_2,
   output logic [31:0] rsp_digest_3,
   output logic [31:0] rsp_digest_4,
   output logic [31:0] rsp_digest_5,
   output logic [31:0] rsp_digest_6,
   output logic [31:0] rsp_digest_7,
   input  logic                   csr_write_en,
   input  sm3_pkg::csr_index_type csr_index,
   input  logic [31:0]            csr_wdata
);
   sm3_pkg::chain_type init_ff, digest;
   sm3_pkg::qent_type  push_data, pop_data;
   logic               push, full, pop, not_empty;

   // initial chaining value registers
   always_ff @(posedge clock) begin
      if (reset) init_ff <= sm3_pkg::IV_RESET;
      else if (csr_write_en) init_ff[csr_index] <= csr_wdata;
   end

   sm3_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_message_word,
      .req_valid_bytes, .req_final_word, .push, .push_data, .full);

   sm3_queue u_queue (
      .clock, .reset, .push, .push_data, .full, .pop, .not_empty, .pop_data);

   sm3_back u_back (
      .clock, .reset, .not_empty, .pop_data, .pop, .init_words(init_ff),
      .rsp_valid, .rsp_stall, .digest);

   assign rsp_digest_0 = digest[0];
   assign rsp_digest_1 = digest[1];
   assign rsp_digest_2 = digest[2];
   assign rsp_digest_3 = digest[3];
   assign rsp_digest_4 = digest[4];
   assign rsp_digest_5 = digest[5];
   assign rsp_digest_6 = digest[6];
   assign rsp_digest_7 = digest[7];

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty) else $error("queue read while empty");
   a_req_implies_push: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> push) else $error("request lost");
endmodule

[rtl/sm3_queue.sv]
// Small word queue between the padding front and the compression back.
module sm3_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  sm3_pkg::qent_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output sm3_pkg::qent_type pop_data
);
   sm3_pkg::qent_type               mem_ff [sm3_pkg::QDEPTH];
   logic [sm3_pkg::QPTR_W-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [sm3_pkg::QPTR_W:0]        count_ff;

   assign full      = (count_ff == (sm3_pkg::QPTR_W+1)'(sm3_pkg::QDEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end
endmodule

[rtl/sm3_front.sv]
// Request front: takes message words, counts the length and writes the padding.
module sm3_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [31:0]       req_message_word,
   input  logic [2:0]        req_valid_bytes,
   input  logic              req_final_word,
   output logic              push,
   output sm3_pkg::qent_type push_data,
   input  logic              full
);
   sm3_pkg::front_state_type state_ff, state_in;
   logic [3:0]  pos_ff;
   logic [63:0] len_ff;
   logic        accept;
   logic [1:0]  nv;
   logic [63:0] len_add;
   logic [5:0]  shift;

   // set when a word carries all four bytes: any non-final word, or a final word with a byte count of 4 or more
   logic full_word;
   assign full_word = !req_final_word || (req_valid_bytes >= 3'd4);
   assign nv        = req_valid_bytes[1:0];
   assign shift     = {1'b0, nv, 3'b000};
   assign len_add   = full_word ? 64'd32 : {59'd0, nv, 3'b000};
   assign req_stall = (state_ff != sm3_pkg::FR_IDLE) || full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sm3_pkg::FR_IDLE:
            if (accept && req_final_word)
               state_in = full_word ? sm3_pkg::FR_PAD80 : sm3_pkg::FR_ZERO;
         sm3_pkg::FR_PAD80:
            if (!full) state_in = sm3_pkg::FR_ZERO;
         sm3_pkg::FR_ZERO:
            if (!full && pos_ff == 4'd14) state_in = sm3_pkg::FR_LEN_LO;
         sm3_pkg::FR_LEN_LO:
            if (!full) state_in = sm3_pkg::FR_IDLE;
         default: state_in = sm3_pkg::FR_IDLE;
      endcase
   end

   always_comb begin
      push           = 1'b0;
      push_data.word = '0;
      push_data.last = 1'b0;
      unique case (state_ff)
         sm3_pkg::FR_IDLE: begin
            push = accept;
            if (full_word) push_data.word = req_message_word;
            else push_data.word = (req_message_word & ~(32'hffffffff >> shift))
                                  | (sm3_pkg::PAD_WORD >> shift);
         end
         sm3_pkg::FR_PAD80: begin
            push           = !full;
            push_data.word = sm3_pkg::PAD_WORD;
         end
         sm3_pkg::FR_ZERO: begin
            push           = !full;
            push_data.word = (pos_ff == 4'd14) ? len_ff[63:32] : '0;
         end
         sm3_pkg::FR_LEN_LO: begin
            push           = !full;
            push_data.word = len_ff[31:0];
            push_data.last = 1'b1;
         end
         default: push = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sm3_pkg::FR_IDLE;
         pos_ff   <= '0;
         len_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (push) pos_ff <= pos_ff + 1'b1;
         if (accept) len_ff <= len_ff + len_add;
         else if (push && state_ff == sm3_pkg::FR_LEN_LO) len_ff <= '0;
      end
   end
endmodule

[rtl/sm3_back.sv]
// Compression back: gathers 16 words, runs 64 rounds and holds the digest.
module sm3_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               not_empty,
   input  sm3_pkg::qent_type  pop_data,
   output logic               pop,
   input  sm3_pkg::chain_type init_words,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output sm3_pkg::chain_type digest
);
   sm3_pkg::back_state_type state_ff, state_in;
   logic [31:0]        win_ff [16];
   logic [3:0]         cnt_ff;
   logic [5:0]         round_ff;
   logic               last_ff, new_msg_ff, rsp_valid_ff;
   sm3_pkg::chain_type chain_ff, work_ff, digest_ff, base, folded;
   logic [31:0]        trot_ff;
   logic [31:0]        a12, ss1, ss2, ffv, ggv, tt1, tt2, w_next;
   logic               early, out_free, load_end, round_end, done_go;

   assign rsp_valid = rsp_valid_ff;
   assign digest    = digest_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign base      = new_msg_ff ? init_words : chain_ff;
   assign early     = (round_ff[5:4] == 2'b00);
   assign load_end  = not_empty && cnt_ff == 4'd15;
   assign round_end = round_ff == 6'd63;
   assign done_go   = !last_ff || out_free;

   always_comb begin
      for (int i = 0; i < 8; i++) folded[i] = chain_ff[i] ^ work_ff[i];
   end

   // round datapath
   always_comb begin
      a12 = sm3_pkg::rotl(work_ff[0], 12);
      ss1 = sm3_pkg::rotl(a12 + work_ff[4] + trot_ff, 7);
      ss2 = ss1 ^ a12;
      ffv = early ? (work_ff[0] ^ work_ff[1] ^ work_ff[2])
                  : ((work_ff[0] & work_ff[1]) | (work_ff[0] & work_ff[2])
                     | (work_ff[1] & work_ff[2]));
      ggv = early ? (work_ff[4] ^ work_ff[5] ^ work_ff[6])
                  : ((work_ff[4] & work_ff[5]) | (~work_ff[4] & work_ff[6]));
      tt1 = ffv + work_ff[3] + ss2 + (win_ff[0] ^ win_ff[4]);
      tt2 = ggv + work_ff[7] + ss1 + win_ff[0];
      w_next = sm3_pkg::perm1(win_ff[0] ^ win_ff[7] ^ sm3_pkg::rotl(win_ff[13], 15))
               ^ sm3_pkg::rotl(win_ff[3], 7) ^ win_ff[10];
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sm3_pkg::BK_LOAD:  if (load_end) state_in = sm3_pkg::BK_ROUND;
         sm3_pkg::BK_ROUND: if (round_end) state_in = sm3_pkg::BK_DONE;
         sm3_pkg::BK_DONE:  if (done_go) state_in = sm3_pkg::BK_LOAD;
         default:           state_in = sm3_pkg::BK_LOAD;
      endcase
   end

   always_comb begin
      pop = 1'b0;
      unique case (state_ff)
         sm3_pkg::BK_LOAD: pop = not_empty;
         default:          pop = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (pop || state_ff == sm3_pkg::BK_ROUND) begin
         for (int i = 0; i < 15; i++) win_ff[i] <= win_ff[i+1];
         win_ff[15] <= pop ? pop_data.word : w_next;
      end
      if (load_end) begin
         last_ff <= pop_data.last;
         work_ff <= base;
         trot_ff <= sm3_pkg::T_LOW;
      end else if (state_ff == sm3_pkg::BK_ROUND) begin
         work_ff <= '{tt1, work_ff[0], sm3_pkg::rotl(work_ff[1], 9), work_ff[2],
                      sm3_pkg::perm0(tt2), work_ff[4], sm3_pkg::rotl(work_ff[5], 19),
                      work_ff[6]};
         trot_ff <= (round_ff == 6'd15) ? sm3_pkg::T_HIGH_16 : sm3_pkg::rotl(trot_ff, 1);
      end
      if (state_ff == sm3_pkg::BK_DONE && done_go && last_ff) digest_ff <= folded;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sm3_pkg::BK_LOAD;
         cnt_ff       <= '0;
         round_ff     <= '0;
         new_msg_ff   <= 1'b1;
         rsp_valid_ff <= 1'b0;
         chain_ff     <= sm3_pkg::IV_RESET;
      end else begin
         state_ff <= state_in;
         if (pop) cnt_ff <= cnt_ff + 1'b1;
         if (state_ff == sm3_pkg::BK_ROUND) round_ff <= round_ff + 1'b1;
         if (load_end) begin
            chain_ff   <= base;
            new_msg_ff <= 1'b0;
         end
         if (state_ff == sm3_pkg::BK_DONE && done_go) begin
            chain_ff <= folded;
            if (last_ff) new_msg_ff <= 1'b1;
         end
         if (state_ff == sm3_pkg::BK_DONE && done_go && last_ff) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end
endmodule

[tb/sm3_digest_checker.sv]
// Digest predictor and scoreboard for the SM3 hash engine.
`timescale 1ns / 100ps
module sm3_digest_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [31:0] req_message_word,
   input  logic [2:0]  req_valid_bytes,
   input  logic        req_final_word,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [31:0] rsp_digest_0,
   input  logic [31:0] rsp_digest_1,
   input  logic [31:0] rsp_digest_2,
   input  logic [31:0] rsp_digest_3,
   input  logic [31:0] rsp_digest_4,
   input  logic [31:0] rsp_digest_5,
   input  logic [31:0] rsp_digest_6,
   input  logic [31:0] rsp_digest_7,
   input  logic        csr_write_en,
   input  sm3_pkg::csr_index_type csr_index,
   input  logic [31:0] csr_wdata,
   output int          fail_count,
   output int          pending_digests
);
   sm3_pkg::chain_type   iv_regs;
   sm3_pkg::chain_type   chain;
   sm3_pkg::word_type    blk [16];
   int                   wpos;
   logic [63:0]          msg_bits;
   logic                 busy;
   sm3_pkg::chain_type   digest_queue [$];

   function automatic sm3_pkg::word_type rol(sm3_pkg::word_type x, int n);
      n = n % 32;
      return (n == 0) ? x : ((x << n) | (x >> (32 - n)));
   endfunction

   function automatic sm3_pkg::word_type p_zero(sm3_pkg::word_type x);
      return x ^ rol(x, 9) ^ rol(x, 17);
   endfunction

   function automatic sm3_pkg::word_type p_one(sm3_pkg::word_type x);
      return x ^ rol(x, 15) ^ rol(x, 23);
   endfunction

   task automatic compress();
      sm3_pkg::word_type w [68];
      sm3_pkg::word_type a, b, c, d, e, f, g, h, a12, ss1, ss2, ff, gg, tt1, tt2, tj;
      for (int j = 0; j < 16; j++) w[j] = blk[j];
      for (int j = 16; j < 68; j++)
         w[j] = p_one(w[j-16] ^ w[j-9] ^ rol(w[j-3], 15)) ^ rol(w[j-13], 7) ^ w[j-6];
      {a, b, c, d, e, f, g, h} = chain;
      for (int j = 0; j < 64; j++) begin
         tj  = (j < 16) ? sm3_pkg::T_LOW : sm3_pkg::T_HIGH;
         a12 = rol(a, 12);
         ss1 = rol(a12 + e + rol(tj, j), 7);
         ss2 = ss1 ^ a12;
         ff  = (j < 16) ? (a ^ b ^ c) : ((a & b) | (a & c) | (b & c));
         gg  = (j < 16) ? (e ^ f ^ g) : ((e & f) | (~e & g));
         tt1 = ff + d + ss2 + (w[j] ^ w[j+4]);
         tt2 = gg + h + ss1 + w[j];
         d = c; c = rol(b, 9); b = a; a = tt1;
         h = g; g = rol(f, 19); f = e; e = p_zero(tt2);
      end
      chain = chain ^ {a, b, c, d, e, f, g, h};
   endtask

   task automatic push_word(sm3_pkg::word_type v);
      blk[wpos] = v;
      wpos++;
      if (wpos == 16) begin
         compress();
         wpos = 0;
      end
   endtask

   task automatic take_request(sm3_pkg::word_type word, logic [2:0] nb_in, logic last);
      int nb;
      sm3_pkg::word_type keep;
      if (!busy) begin
         chain = iv_regs; wpos = 0; msg_bits = '0; busy = 1'b1;
      end
      if (!last) begin
         msg_bits += 32;
         push_word(word);
         return;
      end
      nb = (nb_in > 4) ? 4 : nb_in;
      msg_bits += 64'(nb * 8);
      if (nb == 4) begin
         push_word(word);
         push_word(sm3_pkg::PAD_WORD);
      end else begin
         keep = (nb == 0) ? '0 : (32'hffffffff << (32 - 8 * nb));
         push_word((word & keep) | (sm3_pkg::PAD_WORD >> (8 * nb)));
      end
      if (wpos > 14) push_word('0);
      while (wpos < 14) push_word('0);
      push_word(msg_bits[63:32]);
      push_word(msg_bits[31:0]);
      digest_queue.insert(digest_queue.size(), chain);
      busy = 1'b0;
   endtask

   always @(posedge clock) begin
      sm3_pkg::chain_type want, got;
      if (reset) begin
         iv_regs = sm3_pkg::IV_RESET; busy = 1'b0; wpos = 0; msg_bits = '0;
         digest_queue.delete();
         fail_count = 0;
      end else begin
         if (csr_write_en) iv_regs[csr_index] = csr_wdata;
         if (req_valid && !req_stall)
            take_request(req_message_word, req_valid_bytes, req_final_word);
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_digest_0, rsp_digest_1, rsp_digest_2, rsp_digest_3,
                   rsp_digest_4, rsp_digest_5, rsp_digest_6, rsp_digest_7};
            if (digest_queue.size() == 0) begin
               $error("digest with no request outstanding");
               fail_count++;
            end else begin
               want = digest_queue.pop_front();
               for (int k = 0; k < 8; k++)
                  if (want[k] !== got[k]) begin
                     $error("digest_%0d expected %08h actual %08h", k, want[k], got[k]);
                     fail_count++;
                  end
            end
         end
      end
      pending_digests = digest_queue.size();
   end

endmodule

[tb/tb_sm3_hash_engine.sv]
// Stimulus and verdict for the SM3 hash engine testbench.
`timescale 1ns / 100ps
module tb_sm3_hash_engine;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int RANDOM_WORDS   = 600;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_message_word = '0;
   logic [2:0]  req_valid_bytes = '0;
   logic        req_final_word = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_digest_0, rsp_digest_1, rsp_digest_2, rsp_digest_3;
   logic [31:0] rsp_digest_4, rsp_digest_5, rsp_digest_6, rsp_digest_7;
   logic        csr_write_en = 1'b0;
   sm3_pkg::csr_index_type csr_index = '0;
   logic [31:0] csr_wdata = '0;
   int          fail_count;
   int          pending_digests;
   int          idle_cycles = 0;
   int          sent_words = 0;
   int          stall_phase = 0;

   always #2 clock = ~clock;

   sm3_hash_engine u_dut (.*);
   sm3_digest_checker u_checker (.*);

   // receiver stall pattern: phases of no stall, light stall and heavy stall
   always @(posedge clock) begin
      if ($urandom_range(0, 199) == 0) stall_phase <= $urandom_range(0, 2);
      rsp_stall <= ($urandom_range(0, 9) < ((stall_phase == 0) ? 0 :
                    (stall_phase == 1) ? 3 : 8));
   end

   // watchdog: cycles with no request or digest accepted
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG_LIMIT) begin
         $display("sm3_hash_engine verification failed");
         $finish;
      end
   end

   // one request, held until taken; valid drops only for a random gap before it
   task automatic send_word(logic [31:0] word, logic [2:0] nb, logic last, int gap);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_message_word <= word;
      req_valid_bytes  <= nb;
      req_final_word   <= last;
      do @(posedge clock); while (req_stall);
      sent_words++;
   endtask

   // a message of n_words words; bursts decide the gap before each word
   task automatic send_message(int n_words, logic [2:0] last_nb);
      int burst;
      burst = 0;
      for (int i = 0; i < n_words; i++) begin
         int gap;
         if (burst == 0) begin
            burst = $urandom_range(1, 12);
            gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 10);
         end else gap = 0;
         burst--;
         if (i == n_words - 1) send_word($urandom, last_nb, 1'b1, gap);
         else send_word($urandom, ($urandom_range(0, 3) == 0) ? 3'($urandom) : 3'd4,
                        1'b0, gap);
      end
   endtask

   // CSR writes only once every digest is back, plus a settling gap
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_digests != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic set_iv(int mode);
      for (int k = 0; k < 8; k++) begin
         csr_write_en <= 1'b1;
         csr_index    <= sm3_pkg::csr_index_type'(k);
         csr_wdata    <= (mode == 0) ? 32'h0 : (mode == 1) ? 32'hffffffff :
                         (mode == 2) ? sm3_pkg::IV_RESET[k] : $urandom;
         @(posedge clock);
      end
      csr_write_en <= 1'b0;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: empty message, each tail length, padding into an extra block
      send_word(32'h61626300, 3'd3, 1'b1, 0);       // "abc"
      send_word(32'hffffffff, 3'd0, 1'b1, 0);       // empty message
      send_word(32'h00000000, 3'd4, 1'b1, 0);
      send_word(32'hffffffff, 3'd7, 1'b1, 1);       // byte count saturates
      send_word(32'hdeadbeef, 3'd1, 1'b1, 0);
      send_word(32'hffffffff, 3'd2, 1'b1, 0);
      send_message(14, 3'd4);                       // length needs a second block
      send_message(16, 3'd0);
      drain();
      set_iv(0);
      send_word(32'h12345678, 3'd4, 1'b1, 0);
      send_message(3, 3'd5);
      drain();
      set_iv(1);
      send_message(15, 3'd3);
      drain();
      set_iv(3);
      // random messages, mostly short, some crossing block bounds
      while (sent_words < RANDOM_WORDS) begin
         send_message(($urandom_range(0, 7) == 0) ? $urandom_range(14, 40)
                      : $urandom_range(1, 10), 3'($urandom));
         if ($urandom_range(0, 15) == 0) begin
            drain();
            set_iv($urandom_range(2, 3));
         end
      end
      drain();
      if (fail_count == 0) $display("sm3_hash_engine verification clean");
      else $display("sm3_hash_engine verification failed");
      $finish;
   end

endmodule
